[src/i2cm_pkg.sv]
// Shared types and constants for the I2C register-access master.
package i2cm_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    P_IDLE, P_ST1, P_ST2, P_ST3,
    P_TX1, P_TX2, P_TX3,
    P_WA1, P_WA2, P_WA3,
    P_RX1, P_RX2,
    P_AK1, P_AK2, P_AK3, P_AK4,
    P_SP1, P_SP2, P_SP3, P_SP4
  } phase_e;

  // Which byte of the transaction is on the bus.
  typedef enum logic [2:0] {
    G_WADDR, G_REG, G_DATA, G_RADDR, G_RDATA
  } stage_e;

  typedef struct packed {
    phase_e      phase;
    stage_e      stage;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [7:0]  bytes_left;
    logic [6:0]  addr;
    logic [7:0]  regb;
    logic        is_read;
    logic        failing;
    logic        scl;
    logic        sda;
  } eng_state_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        byte_taken;
    logic [7:0]  rd_data;
    logic        rd_valid;
    logic        done_res;
    logic        success;
    logic [15:0] fail_count;
  } rsp_t;

endpackage

[src/i2cm_if.sv]
// Request and response channel interfaces of the I2C register-access master.
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] wr_data;
  logic       sda_in;

  modport source (output valid, req_type, dev_addr, reg_addr, byte_count, wr_data, sda_in,
                  input ready);
  modport sink   (input valid, req_type, dev_addr, reg_addr, byte_count, wr_data, sda_in,
                  output ready);
endinterface

interface i2cm_rsp_if;
  logic        valid;
  logic        ready;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        byte_taken;
  logic [7:0]  rd_data;
  logic        rd_valid;
  logic        done_res;
  logic        success;
  logic [15:0] fail_count;

  modport source (output valid, scl_out, sda_out, busy_res, byte_taken, rd_data, rd_valid,
                         done_res, success, fail_count,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, byte_taken, rd_data, rd_valid,
                        done_res, success, fail_count,
                  output ready);
endinterface

[src/i2cm_engine.sv]
// Bus phase engine: state registers and the next-phase logic for one request.
module i2cm_engine import i2cm_pkg::*; #(
  parameter int FAIL_COUNT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [1:0] req_type_i,
  input  logic [6:0] dev_addr_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] byte_count_i,
  input  logic [7:0] wr_data_i,
  input  logic       sda_in_i,
  output rsp_t       rsp_o
);

  eng_state_t st_q, st_d;
  logic [FAIL_COUNT_BITS-1:0] failures_q, failures_d;
  logic [FAIL_COUNT_BITS+15:0] fail_ext;
  logic       fail_inc, taken, rvalid, done, ok;
  logic [7:0] rd;
  logic [3:0] bc_dec;
  logic [7:0] bl_dec;

  assign bc_dec = st_q.bit_cnt - 4'd1;
  assign bl_dec = st_q.bytes_left - 8'd1;

  always_comb begin
    st_d     = st_q;
    fail_inc = 1'b0;
    taken    = 1'b0;
    rvalid   = 1'b0;
    done     = 1'b0;
    ok       = 1'b0;
    rd       = 8'd0;
    if (req_type_i inside {REQ_WRITE, REQ_READ}) begin
      // A begin request while busy is ignored.
      if (st_q.phase == P_IDLE) begin
        st_d.addr       = dev_addr_i;
        st_d.regb       = reg_addr_i;
        st_d.bytes_left = byte_count_i;
        st_d.is_read    = (req_type_i == REQ_READ);
        st_d.stage      = G_WADDR;
        st_d.failing    = 1'b0;
        st_d.bit_cnt    = 4'd0;
        st_d.phase      = P_ST1;
      end
    end else begin
      case (st_q.phase)
        P_IDLE: ;
        P_ST1: begin
          st_d.scl = 1'b1;
          st_d.sda = 1'b1;
          if (st_q.stage != G_RADDR && !sda_in_i) begin
            done = 1'b1; fail_inc = 1'b1; st_d.phase = P_IDLE;
          end else begin
            st_d.phase = P_ST2;
          end
        end
        P_ST2: begin
          st_d.sda = 1'b0;
          if (st_q.stage != G_RADDR && sda_in_i) begin
            done = 1'b1; fail_inc = 1'b1; st_d.phase = P_IDLE;
          end else begin
            st_d.phase = P_ST3;
          end
        end
        P_ST3: begin
          st_d.scl     = 1'b0;
          st_d.shift   = {st_q.addr, st_q.stage == G_RADDR};
          st_d.bit_cnt = BITS_PER_BYTE;
          st_d.phase   = P_TX1;
        end
        P_TX1: begin
          st_d.scl = 1'b0;
          // Data bytes pick up the write byte on their first phase.
          if (st_q.stage == G_DATA && st_q.bit_cnt == BITS_PER_BYTE) begin
            st_d.shift = wr_data_i;
            taken      = 1'b1;
          end
          st_d.phase = P_TX2;
        end
        P_TX2: begin
          st_d.sda   = st_q.shift[7];
          st_d.shift = {st_q.shift[6:0], 1'b0};
          st_d.phase = P_TX3;
        end
        P_TX3: begin
          st_d.scl     = 1'b1;
          st_d.bit_cnt = bc_dec;
          st_d.phase   = (bc_dec == 4'd0) ? P_WA1 : P_TX1;
        end
        P_WA1: begin
          st_d.scl = 1'b0; st_d.phase = P_WA2;
        end
        P_WA2: begin
          st_d.sda = 1'b1; st_d.phase = P_WA3;
        end
        P_WA3: begin
          st_d.scl = 1'b1;
          case (st_q.stage)
            G_WADDR: begin
              if (sda_in_i) begin
                st_d.failing = 1'b1; st_d.phase = P_SP1;
              end else begin
                st_d.stage   = G_REG;
                st_d.shift   = st_q.regb;
                st_d.bit_cnt = BITS_PER_BYTE;
                st_d.phase   = P_TX1;
              end
            end
            G_REG: begin
              if (st_q.is_read) begin
                st_d.stage = G_RADDR; st_d.phase = P_ST1;
              end else if (st_q.bytes_left == 8'd0) begin
                st_d.phase = P_SP1;
              end else begin
                st_d.stage   = G_DATA;
                st_d.shift   = 8'd0;
                st_d.bit_cnt = BITS_PER_BYTE;
                st_d.phase   = P_TX1;
              end
            end
            G_DATA: begin
              if (sda_in_i) begin
                st_d.failing = 1'b1; st_d.phase = P_SP1;
              end else begin
                st_d.bytes_left = bl_dec;
                if (bl_dec == 8'd0) begin
                  st_d.phase = P_SP1;
                end else begin
                  st_d.shift   = 8'd0;
                  st_d.bit_cnt = BITS_PER_BYTE;
                  st_d.phase   = P_TX1;
                end
              end
            end
            default: begin
              if (st_q.bytes_left == 8'd0) begin
                st_d.phase = P_SP1;
              end else begin
                st_d.stage   = G_RDATA;
                st_d.shift   = 8'd0;
                st_d.bit_cnt = BITS_PER_BYTE;
                st_d.phase   = P_RX1;
              end
            end
          endcase
        end
        P_RX1: begin
          st_d.scl = 1'b0; st_d.sda = 1'b1; st_d.phase = P_RX2;
        end
        P_RX2: begin
          st_d.scl     = 1'b1;
          st_d.shift   = {st_q.shift[6:0], sda_in_i};
          st_d.bit_cnt = bc_dec;
          if (bc_dec == 4'd0) begin
            rd = st_d.shift; rvalid = 1'b1; st_d.phase = P_AK1;
          end else begin
            st_d.phase = P_RX1;
          end
        end
        P_AK1: begin
          st_d.scl = 1'b0; st_d.phase = P_AK2;
        end
        P_AK2: begin
          // The last byte is answered with NACK.
          st_d.sda = (st_q.bytes_left == 8'd1); st_d.phase = P_AK3;
        end
        P_AK3: begin
          st_d.scl = 1'b1; st_d.phase = P_AK4;
        end
        P_AK4: begin
          st_d.scl        = 1'b0;
          st_d.bytes_left = bl_dec;
          if (bl_dec == 8'd0) begin
            st_d.phase = P_SP1;
          end else begin
            st_d.shift   = 8'd0;
            st_d.bit_cnt = BITS_PER_BYTE;
            st_d.phase   = P_RX1;
          end
        end
        P_SP1: begin
          st_d.scl = 1'b0; st_d.phase = P_SP2;
        end
        P_SP2: begin
          st_d.sda = 1'b0; st_d.phase = P_SP3;
        end
        P_SP3: begin
          st_d.scl = 1'b1; st_d.phase = P_SP4;
        end
        P_SP4: begin
          st_d.sda     = 1'b1;
          done         = 1'b1;
          fail_inc     = st_q.failing;
          ok           = !st_q.failing;
          st_d.failing = 1'b0;
          st_d.phase   = P_IDLE;
        end
        default: st_d.phase = P_IDLE;
      endcase
    end
  end

  assign failures_d = fail_inc ? failures_q + FAIL_COUNT_BITS'(1) : failures_q;
  assign fail_ext   = (FAIL_COUNT_BITS + 16)'(failures_d);

  always_comb begin
    rsp_o.scl_out    = st_d.scl;
    rsp_o.sda_out    = st_d.sda;
    rsp_o.busy_res   = (st_d.phase != P_IDLE);
    rsp_o.byte_taken = taken;
    rsp_o.rd_data    = rd;
    rsp_o.rd_valid   = rvalid;
    rsp_o.done_res   = done;
    rsp_o.success    = ok;
    rsp_o.fail_count = fail_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= P_IDLE;
      st_q.stage      <= G_WADDR;
      st_q.bit_cnt    <= 4'd0;
      st_q.shift      <= 8'd0;
      st_q.bytes_left <= 8'd0;
      st_q.addr       <= 7'd0;
      st_q.regb       <= 8'd0;
      st_q.is_read    <= 1'b0;
      st_q.failing    <= 1'b0;
      st_q.scl        <= 1'b1;
      st_q.sda        <= 1'b1;
      failures_q      <= '0;
    end else if (adv_i) begin
      st_q       <= st_d;
      failures_q <= failures_d;
    end
  end

endmodule

[src/i2c_master_register_access.sv]
// Top level of the I2C register-access master: request handshake, phase engine, result register.
// Each request is one bus phase tick or a begin-write / begin-read; every request yields exactly
// one response carrying the SCL and SDA drive levels after that phase plus status. A request is
// accepted at a clock edge and its response is loaded into the result register at that same edge,
// so it is offered from the following cycle on. One request per clock is sustained whenever the
// response side keeps taking results; the only limit is the single result register, which accepts
// a new request in the same cycle it is emptied. A transaction lasts one begin request plus as
// many ticks as its bus phases: 3 for a start, 27 for a sent byte (eight bits of three phases and
// a three-phase ACK wait), 20 for a received byte (eight bits of two phases and a four-phase
// ACK or NACK) and 4 for the stop.
module i2c_master_register_access import i2cm_pkg::*; #(
  parameter int FAIL_COUNT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cm_req_if.sink      req_i,
  i2cm_rsp_if.source    rsp_o
);

  logic accept;
  logic out_valid_q;
  rsp_t rsp_d, rsp_q;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  i2cm_engine #(
    .FAIL_COUNT_BITS(FAIL_COUNT_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (accept),
    .req_type_i  (req_i.req_type),
    .dev_addr_i  (req_i.dev_addr),
    .reg_addr_i  (req_i.reg_addr),
    .byte_count_i(req_i.byte_count),
    .wr_data_i   (req_i.wr_data),
    .sda_in_i    (req_i.sda_in),
    .rsp_o       (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.scl_out    = rsp_q.scl_out;
  assign rsp_o.sda_out    = rsp_q.sda_out;
  assign rsp_o.busy_res   = rsp_q.busy_res;
  assign rsp_o.byte_taken = rsp_q.byte_taken;
  assign rsp_o.rd_data    = rsp_q.rd_data;
  assign rsp_o.rd_valid   = rsp_q.rd_valid;
  assign rsp_o.done_res   = rsp_q.done_res;
  assign rsp_o.success    = rsp_q.success;
  assign rsp_o.fail_count = rsp_q.fail_count;

endmodule

[test/tb_i2c_master_register_access.sv]
// Testbench for the I2C register-access master, checked against a phase-level predictor.
module tb_i2c_master_register_access;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // The request encoding treats the unused code as a plain tick.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } i2c_req_t;

  class i2cm_scoreboard;
    phase_e     phase;
    stage_e     stage;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] bytes_left;
    logic [6:0] addr;
    logic [7:0] regb;
    logic       is_read;
    logic       failing;
    logic       scl;
    logic       sda;
    logic [15:0] fails;
    rsp_t       expected_q[$];
    int         errors;

    function new();
      phase = P_IDLE;
      stage = G_WADDR;
      bit_cnt = '0;
      shift = '0;
      bytes_left = '0;
      addr = '0;
      regb = '0;
      is_read = 1'b0;
      failing = 1'b0;
      scl = 1'b1;
      sda = 1'b1;
      fails = '0;
      errors = 0;
    endfunction

    function void load_byte(logic [7:0] value);
      shift = value;
      bit_cnt = BITS_PER_BYTE;
      phase = P_TX1;
    endfunction

    // Moves the bus engine by one request and returns the response it should produce.
    function rsp_t advance(i2c_req_t r);
      rsp_t o;
      o = '0;
      if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
        if (phase == P_IDLE) begin
          addr = r.dev_addr;
          regb = r.reg_addr;
          bytes_left = r.byte_count;
          is_read = (r.req_type == REQ_READ);
          stage = G_WADDR;
          failing = 1'b0;
          bit_cnt = '0;
          phase = P_ST1;
        end
      end else begin
        case (phase)
          P_ST1: begin
            scl = 1'b1;
            sda = 1'b1;
            if (stage != G_RADDR && !r.sda_in) begin
              o.done_res = 1'b1;
              fails++;
              phase = P_IDLE;
            end else begin
              phase = P_ST2;
            end
          end
          P_ST2: begin
            sda = 1'b0;
            if (stage != G_RADDR && r.sda_in) begin
              o.done_res = 1'b1;
              fails++;
              phase = P_IDLE;
            end else begin
              phase = P_ST3;
            end
          end
          P_ST3: begin
            scl = 1'b0;
            load_byte({addr, stage == G_RADDR});
          end
          P_TX1: begin
            scl = 1'b0;
            if (stage == G_DATA && bit_cnt == BITS_PER_BYTE) begin
              shift = r.wr_data;
              o.byte_taken = 1'b1;
            end
            phase = P_TX2;
          end
          P_TX2: begin
            sda = shift[7];
            shift = shift << 1;
            phase = P_TX3;
          end
          P_TX3: begin
            scl = 1'b1;
            bit_cnt--;
            phase = (bit_cnt == 0) ? P_WA1 : P_TX1;
          end
          P_WA1: begin
            scl = 1'b0;
            phase = P_WA2;
          end
          P_WA2: begin
            sda = 1'b1;
            phase = P_WA3;
          end
          P_WA3: begin
            scl = 1'b1;
            case (stage)
              G_WADDR: begin
                if (r.sda_in) begin
                  failing = 1'b1;
                  phase = P_SP1;
                end else begin
                  stage = G_REG;
                  load_byte(regb);
                end
              end
              G_REG: begin
                if (is_read) begin
                  stage = G_RADDR;
                  phase = P_ST1;
                end else if (bytes_left == 0) begin
                  phase = P_SP1;
                end else begin
                  stage = G_DATA;
                  load_byte(8'h00);
                end
              end
              G_DATA: begin
                if (r.sda_in) begin
                  failing = 1'b1;
                  phase = P_SP1;
                end else begin
                  bytes_left--;
                  if (bytes_left == 0) phase = P_SP1;
                  else load_byte(8'h00);
                end
              end
              default: begin
                if (bytes_left == 0) begin
                  phase = P_SP1;
                end else begin
                  stage = G_RDATA;
                  shift = '0;
                  bit_cnt = BITS_PER_BYTE;
                  phase = P_RX1;
                end
              end
            endcase
          end
          P_RX1: begin
            scl = 1'b0;
            sda = 1'b1;
            phase = P_RX2;
          end
          P_RX2: begin
            scl = 1'b1;
            shift = {shift[6:0], r.sda_in};
            bit_cnt--;
            if (bit_cnt == 0) begin
              o.rd_data = shift;
              o.rd_valid = 1'b1;
              phase = P_AK1;
            end else begin
              phase = P_RX1;
            end
          end
          P_AK1: begin
            scl = 1'b0;
            phase = P_AK2;
          end
          P_AK2: begin
            // The last byte of a read is answered with NACK.
            sda = (bytes_left == 8'd1);
            phase = P_AK3;
          end
          P_AK3: begin
            scl = 1'b1;
            phase = P_AK4;
          end
          P_AK4: begin
            scl = 1'b0;
            bytes_left--;
            if (bytes_left == 0) begin
              phase = P_SP1;
            end else begin
              shift = '0;
              bit_cnt = BITS_PER_BYTE;
              phase = P_RX1;
            end
          end
          P_SP1: begin
            scl = 1'b0;
            phase = P_SP2;
          end
          P_SP2: begin
            sda = 1'b0;
            phase = P_SP3;
          end
          P_SP3: begin
            scl = 1'b1;
            phase = P_SP4;
          end
          P_SP4: begin
            sda = 1'b1;
            o.done_res = 1'b1;
            if (failing) fails++;
            else o.success = 1'b1;
            failing = 1'b0;
            phase = P_IDLE;
          end
          default: phase = P_IDLE;
        endcase
      end
      o.scl_out = scl;
      o.sda_out = sda;
      o.busy_res = (phase != P_IDLE);
      o.fail_count = fails;
      return o;
    endfunction

    function void note_request(i2c_req_t r);
      expected_q.push_back(advance(r));
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with no request waiting, expected none got %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("scl_out", 16'(want.scl_out), 16'(got.scl_out));
      check_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
      check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
      check_field("byte_taken", 16'(want.byte_taken), 16'(got.byte_taken));
      check_field("rd_data", 16'(want.rd_data), 16'(got.rd_data));
      check_field("rd_valid", 16'(want.rd_valid), 16'(got.rd_valid));
      check_field("done_res", 16'(want.done_res), 16'(got.done_res));
      check_field("success", 16'(want.success), 16'(got.success));
      check_field("fail_count", want.fail_count, got.fail_count);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i2cm_req_if req_if ();
  i2cm_rsp_if rsp_if ();

  i2c_master_register_access dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  i2cm_scoreboard bus_sb = new();
  // Second copy of the engine, run ahead by the generator to pick sensible SDA levels.
  i2cm_scoreboard bus_plan = new();

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned n_items = 0;
  int unsigned item_goal = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Response side: checks every accepted response and stalls at random.
  initial begin
    rsp_t got;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{scl_out: rsp_if.scl_out, sda_out: rsp_if.sda_out, busy_res: rsp_if.busy_res,
                byte_taken: rsp_if.byte_taken, rd_data: rsp_if.rd_data,
                rd_valid: rsp_if.rd_valid, done_res: rsp_if.done_res,
                success: rsp_if.success, fail_count: rsp_if.fail_count};
        bus_sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_req(input i2c_req_t r);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.req_type;
    req_if.dev_addr   <= r.dev_addr;
    req_if.reg_addr   <= r.reg_addr;
    req_if.byte_count <= r.byte_count;
    req_if.wr_data    <= r.wr_data;
    req_if.sda_in     <= r.sda_in;
    do @(posedge clk_i); while (!req_if.ready);
    bus_sb.note_request(r);
  endtask

  task automatic issue(input i2c_req_t r);
    bit counted;
    if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) counted = (bus_plan.phase == P_IDLE);
    else counted = (bus_plan.phase != P_IDLE);
    void'(bus_plan.advance(r));
    if (counted) n_items++;
    send_req(r);
  endtask

  function automatic i2c_req_t random_req(logic [1:0] kind);
    i2c_req_t r;
    r = $bits(i2c_req_t)'({$urandom, $urandom});
    r.req_type = kind;
    return r;
  endfunction

  // A target that mostly behaves: start levels correct, addresses and data ACKed.
  function automatic logic pick_sda(bit nack_addr);
    logic level;
    level = ($urandom_range(1) != 0);
    case (bus_plan.phase)
      P_ST1: if (bus_plan.stage != G_RADDR) level = ($urandom_range(39) != 0);
      P_ST2: if (bus_plan.stage != G_RADDR) level = ($urandom_range(39) == 0);
      P_WA3: begin
        if (bus_plan.stage == G_WADDR) level = nack_addr || ($urandom_range(29) == 0);
        else if (bus_plan.stage == G_DATA) level = ($urandom_range(11) == 0);
      end
      default: ;
    endcase
    return level;
  endfunction

  task automatic tick(input bit nack_addr);
    i2c_req_t r;
    r = random_req(($urandom_range(19) == 0) ? REQ_SPARE : REQ_TICK);
    r.sda_in = pick_sda(nack_addr);
    issue(r);
  endtask

  // A transaction still open when the phase quota is reached is carried on by the next one.
  task automatic run_transaction(input logic [1:0] kind, input logic [7:0] count,
                                 input bit nack_addr);
    i2c_req_t r;
    r = random_req(kind);
    r.byte_count = count;
    issue(r);
    while (bus_plan.phase != P_IDLE && n_items < item_goal) begin
      // A begin while busy must be ignored by the engine.
      if ($urandom_range(32) == 0) issue(random_req($urandom_range(1) ? REQ_WRITE : REQ_READ));
      tick(nack_addr);
    end
  endtask

  task automatic random_transaction();
    int unsigned k;
    logic [1:0] kind;
    logic [7:0] count;
    bit nack_addr;
    repeat ($urandom_range(2)) tick(1'b0);
    k = $urandom_range(99);
    kind = $urandom_range(1) ? REQ_WRITE : REQ_READ;
    nack_addr = 1'b0;
    if (k < 15) begin
      count = 8'd0;
    end else if (k < 85) begin
      count = 8'($urandom_range(3, 1));
    end else begin
      // Long counts are cut short by an address NACK to keep the run brief.
      count = 8'($urandom_range(255, 4));
      nack_addr = 1'b1;
    end
    run_transaction(kind, count, nack_addr);
  endtask

  task automatic directed_item(input logic [1:0] kind, input logic [6:0] da,
                               input logic [7:0] ra, input logic [7:0] cnt,
                               input logic [7:0] wd, input logic sda);
    i2c_req_t r;
    r = '{req_type: kind, dev_addr: da, reg_addr: ra, byte_count: cnt, wr_data: wd,
          sda_in: sda};
    issue(r);
  endtask

  localparam int unsigned ITEM_TARGET = 450;

  initial begin
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_TICK;
    req_if.dev_addr   <= '0;
    req_if.reg_addr   <= '0;
    req_if.byte_count <= '0;
    req_if.wr_data    <= '0;
    req_if.sda_in     <= 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ticks while idle change nothing.
    directed_item(REQ_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    directed_item(REQ_SPARE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    // Start check failing on the first phase: SDA held low.
    directed_item(REQ_WRITE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    directed_item(REQ_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    // Start check failing on the second phase: SDA stuck high.
    directed_item(REQ_READ, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    directed_item(REQ_TICK, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    directed_item(REQ_SPARE, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    // A begin while busy is dropped; then the start fails again.
    directed_item(REQ_WRITE, 7'h55, 8'haa, 8'h01, 8'h5a, 1'b1);
    directed_item(REQ_READ, 7'h2a, 8'h55, 8'hfe, 8'ha5, 1'b0);
    directed_item(REQ_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    directed_item(REQ_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  hold_left = 80; end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      item_goal = (ph + 1) * ITEM_TARGET / 4;
      while (n_items < item_goal) random_transaction();
    end
    req_if.valid <= 1'b0;
    stall_pct = 0;

    while (bus_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (bus_sb.errors == 0 && bus_sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
